// ===== sv/touch_pinch_gesture_tracker_assert.svh =====
// assertion macros for the pinch gesture tracker
// no dependencies; included by modules that carry assertions
`ifndef TOUCH_PINCH_GESTURE_TRACKER_ASSERT_SVH
`define TOUCH_PINCH_GESTURE_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpg assertion failed");
// next-cycle implication
`define TPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpg assertion failed");
`else
`define TPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/tpg_pkg.sv =====
// types and constants shared by the pinch gesture tracker
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package tpg_pkg;

  // coordinate and distance formats
  localparam int COORD_BITS     = 12;
  localparam int DIST_FRAC_BITS = 4;
  localparam int SQ_BITS        = 2 * COORD_BITS + 1;
  localparam int RAD_BITS       = ((SQ_BITS + 1) / 2) * 2 + 2 * DIST_FRAC_BITS;
  localparam int SQRT_STEPS     = RAD_BITS / 2;
  localparam int DIST_BITS      = 17;
  localparam int UNIT_BITS      = DIST_BITS + 3;

  // ratio format
  localparam int Q14_BITS  = 15;
  localparam int DIV_STEPS = Q14_BITS;
  localparam int CNT_BITS  = $clog2(SQRT_STEPS);
  localparam logic [Q14_BITS-1:0] RATIO_MIN_Q14 = 15'd12288;
  localparam logic [Q14_BITS-1:0] RATIO_MAX_Q14 = 15'd20480;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 15;
  localparam int MIN_DIST_BITS = 14;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DIST  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_TRG = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_TRG = 3'd4;

  typedef struct packed {
    logic [3:0]            touch_count;
    logic [COORD_BITS-1:0] first_x_raw;
    logic [COORD_BITS-1:0] first_y_raw;
    logic [COORD_BITS-1:0] second_x_raw;
    logic [COORD_BITS-1:0] second_y_raw;
  } tpg_in_t;

  typedef struct packed {
    logic                  pressed;
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  zoom_valid;
    logic [Q14_BITS-1:0]   zoom_scale_q14;
  } tpg_out_t;

endpackage

`default_nettype wire

// ===== sv/tpg_in_if.sv =====
// touch report channel: valid, ready and one report
// depends on tpg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tpg_in_if;
  logic             valid;
  logic             ready;
  tpg_pkg::tpg_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/tpg_out_if.sv =====
// result channel: valid, ready and one tracker result
// depends on tpg_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tpg_out_if;
  logic              valid;
  logic              ready;
  tpg_pkg::tpg_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/touch_pinch_gesture_tracker.sv =====
// pinch gesture tracker: clamp, distance square root, ratio division
// depends on tpg_pkg, tpg_in_if, tpg_out_if and touch_pinch_gesture_tracker_assert.svh
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake         payload
// in_chan   in   valid/ready       touch_count, two raw points
// out_chan  out  valid/ready       pressed, point, zoom_valid, zoom_scale_q14
// cfg_*     in   write enable      5 registers, index and 15-bit data
//
// fewer than two touches: difference step, then straight to publishing the result
// two touches: differences, squares, sum, square root and ratio check; with no ratio the
// result follows, else the ratio saturates or runs the division before the clamp; the
// 17-step square root and 15-step division share one 20-bit subtract and compare unit
// one report at a time: in_chan.ready is high only while the sequencer idles
// a result waits in the output register; the sequencer holds in its last step
// until that register is free. reset is synchronous, no clearing pass
module touch_pinch_gesture_tracker (
  input  wire                                  clk,
  input  wire                                  rst_n,
  tpg_in_if.sink                               in_chan,
  tpg_out_if.source                            out_chan,
  input  wire                                  cfg_we,
  input  wire  [tpg_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  wire  [tpg_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import tpg_pkg::*;

`include "touch_pinch_gesture_tracker_assert.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIFF  = 4'd1;
  localparam logic [3:0] S_SQX   = 4'd2;
  localparam logic [3:0] S_SQY   = 4'd3;
  localparam logic [3:0] S_SUM   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_CLAMP = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam int PROD_BITS = 2 * COORD_BITS;

  // control state
  logic [3:0]                state_r, state_nxt;
  logic [CNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic                      trk_r, trk_nxt;
  logic [DIST_BITS-1:0]      last_r, last_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // configuration registers
  logic [COORD_BITS-1:0]     xlim_r, xlim_nxt;
  logic [COORD_BITS-1:0]     ylim_r, ylim_nxt;
  logic [MIN_DIST_BITS-1:0]  min_r, min_nxt;
  logic [Q14_BITS-1:0]       upper_r, upper_nxt;
  logic [Q14_BITS-1:0]       lower_r, lower_nxt;

  // datapath registers
  logic [3:0]                count_r, count_nxt;
  logic [COORD_BITS-1:0]     x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [COORD_BITS-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic [PROD_BITS-1:0]      prod_r, prod_nxt, sq_r, sq_nxt;
  logic [RAD_BITS-1:0]       rad_r, rad_nxt;
  logic [DIST_BITS:0]        rem_r, rem_nxt;
  logic [DIST_BITS-1:0]      root_r, root_nxt;
  logic [Q14_BITS-1:0]       q_r, q_nxt;
  logic                      sat_r, sat_nxt;
  logic                      zv_r, zv_nxt;
  logic [Q14_BITS-1:0]       zs_r, zs_nxt;
  tpg_out_t                  out_r, out_nxt;

  // shared subtract and compare unit
  logic [UNIT_BITS-1:0]      unit_a, unit_b;
  logic [UNIT_BITS:0]        unit_sub;
  logic                      unit_ge;

  // helpers
  logic                      in_acc;
  logic                      out_free;
  logic [PROD_BITS:0]        sq_sum;
  logic [DIST_BITS-1:0]      min_ext;
  logic                      ratio_ok;
  logic [Q14_BITS-1:0]       ratio_raw, ratio_clamped;
  logic [DIST_BITS-1:0]      div_rest;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  // unit operands: square root trial or division trial
  always_comb begin
    if (state_r == S_SQRT) begin
      unit_a = {rem_r, rad_r[RAD_BITS-1 -: 2]};
      unit_b = {1'b0, root_r, 2'b01};
    end else begin
      unit_a = {2'b00, rem_r};
      unit_b = {3'b000, last_r};
    end
  end

  assign unit_sub = {1'b0, unit_a} - {1'b0, unit_b};
  assign unit_ge  = ~unit_sub[UNIT_BITS];
  assign div_rest = unit_ge ? unit_sub[DIST_BITS-1:0] : unit_a[DIST_BITS-1:0];

  assign sq_sum  = {1'b0, sq_r} + {1'b0, prod_r};
  assign min_ext = {{(DIST_BITS-MIN_DIST_BITS){1'b0}}, min_r};

  // ratio needs tracking, a nonzero previous distance and both distances at or above the minimum
  assign ratio_ok = trk_r && (last_r != '0) && (last_r >= min_ext) && (root_r >= min_ext);

  // clamp the quotient to 0.75..1.25
  always_comb begin
    ratio_raw = sat_r ? RATIO_MAX_Q14 : q_r;
    if (ratio_raw < RATIO_MIN_Q14) begin
      ratio_clamped = RATIO_MIN_Q14;
    end else if (ratio_raw > RATIO_MAX_Q14) begin
      ratio_clamped = RATIO_MAX_Q14;
    end else begin
      ratio_clamped = ratio_raw;
    end
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    trk_nxt       = trk_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    xlim_nxt      = xlim_r;
    ylim_nxt      = ylim_r;
    min_nxt       = min_r;
    upper_nxt     = upper_r;
    lower_nxt     = lower_r;
    count_nxt     = count_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    prod_nxt      = prod_r;
    sq_nxt        = sq_r;
    rad_nxt       = rad_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    q_nxt         = q_r;
    sat_nxt       = sat_r;
    zv_nxt        = zv_r;
    zs_nxt        = zs_r;
    out_nxt       = out_r;

    // configuration writes
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_SCREEN_X:  xlim_nxt  = cfg_wdata[COORD_BITS-1:0];
        REG_SCREEN_Y:  ylim_nxt  = cfg_wdata[COORD_BITS-1:0];
        REG_MIN_DIST:  min_nxt   = cfg_wdata[MIN_DIST_BITS-1:0];
        REG_UPPER_TRG: upper_nxt = cfg_wdata[Q14_BITS-1:0];
        REG_LOWER_TRG: lower_nxt = cfg_wdata[Q14_BITS-1:0];
        default: ;
      endcase
    end

    // output register drains
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          count_nxt = in_chan.data.touch_count;
          x1_nxt = (in_chan.data.first_x_raw > xlim_r) ? xlim_r : in_chan.data.first_x_raw;
          y1_nxt = (in_chan.data.first_y_raw > ylim_r) ? ylim_r : in_chan.data.first_y_raw;
          x2_nxt = (in_chan.data.second_x_raw > xlim_r) ? xlim_r : in_chan.data.second_x_raw;
          y2_nxt = (in_chan.data.second_y_raw > ylim_r) ? ylim_r : in_chan.data.second_y_raw;
          zv_nxt = 1'b0;
          zs_nxt = '0;
          sat_nxt = 1'b0;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        dx_nxt = (x2_r >= x1_r) ? (x2_r - x1_r) : (x1_r - x2_r);
        dy_nxt = (y2_r >= y1_r) ? (y2_r - y1_r) : (y1_r - y2_r);
        state_nxt = (count_r < 4'd2) ? S_DONE : S_SQX;
      end
      S_SQX: begin
        prod_nxt = dx_r * dx_r;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sq_nxt = prod_r;
        prod_nxt = dy_r * dy_r;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        rad_nxt = RAD_BITS'({sq_sum, {(2*DIST_FRAC_BITS){1'b0}}});
        rem_nxt = '0;
        root_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      // one root bit per cycle
      S_SQRT: begin
        rem_nxt = unit_ge ? unit_sub[DIST_BITS:0] : unit_a[DIST_BITS:0];
        root_nxt = {root_r[DIST_BITS-2:0], unit_ge};
        rad_nxt = rad_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(SQRT_STEPS - 1)) begin
          state_nxt = S_CHK;
        end
      end
      // decide on a ratio; quotient of 2.0 or more saturates at once
      S_CHK: begin
        cnt_nxt = '0;
        q_nxt = '0;
        rem_nxt = {1'b0, root_r};
        if (!ratio_ok) begin
          state_nxt = S_DONE;
        end else if ({1'b0, root_r} >= {last_r, 1'b0}) begin
          sat_nxt = 1'b1;
          state_nxt = S_CLAMP;
        end else begin
          state_nxt = S_DIV;
        end
      end
      // one quotient bit per cycle
      S_DIV: begin
        rem_nxt = {div_rest, 1'b0};
        q_nxt = {q_r[Q14_BITS-2:0], unit_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_BITS'(DIV_STEPS - 1)) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if ((ratio_clamped > upper_r) || (ratio_clamped < lower_r)) begin
          zv_nxt = 1'b1;
          zs_nxt = ratio_clamped;
        end
        state_nxt = S_DONE;
      end
      // publish the result and update tracking
      S_DONE: begin
        if (out_free) begin
          out_nxt.pressed        = (count_r != 4'd0);
          out_nxt.point_x        = (count_r != 4'd0) ? x1_r : '0;
          out_nxt.point_y        = (count_r != 4'd0) ? y1_r : '0;
          out_nxt.zoom_valid     = zv_r;
          out_nxt.zoom_scale_q14 = zs_r;
          out_valid_nxt = 1'b1;
          if (count_r < 4'd2) begin
            trk_nxt = 1'b0;
            last_nxt = '0;
          end else begin
            trk_nxt = 1'b1;
            last_nxt = root_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      trk_r       <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      xlim_r      <= 12'd319;
      ylim_r      <= 12'd479;
      min_r       <= 14'd192;
      upper_r     <= 15'd16793;
      lower_r     <= 15'd15975;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      trk_r       <= trk_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      xlim_r      <= xlim_nxt;
      ylim_r      <= ylim_nxt;
      min_r       <= min_nxt;
      upper_r     <= upper_nxt;
      lower_r     <= lower_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    x1_r    <= x1_nxt;
    y1_r    <= y1_nxt;
    x2_r    <= x2_nxt;
    y2_r    <= y2_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    prod_r  <= prod_nxt;
    sq_r    <= sq_nxt;
    rad_r   <= rad_nxt;
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    q_r     <= q_nxt;
    sat_r   <= sat_nxt;
    zv_r    <= zv_nxt;
    zs_r    <= zs_nxt;
    out_r   <= out_nxt;
  end

  // checks on the sequencer and the result
  `TPG_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_acc, state_r == S_DIFF)
  `TPG_ASSERT_IMPL(a_sqrt_count, clk, rst_n, state_r == S_SQRT,
                   cnt_r < CNT_BITS'(SQRT_STEPS))
  `TPG_ASSERT_IMPL(a_zoom_range, clk, rst_n, out_valid_r && out_r.zoom_valid,
                   (out_r.zoom_scale_q14 >= RATIO_MIN_Q14) &&
                   (out_r.zoom_scale_q14 <= RATIO_MAX_Q14) && out_r.pressed)
  `TPG_ASSERT_IMPL(a_zoom_needs_track, clk, rst_n, state_r == S_DIV, trk_r)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the two-finger pinch tracker
// drives report and config ports, predicts each result and compares it
// depends on tpg_pkg, tpg_in_if, tpg_out_if and the tracker rtl
`timescale 1ns / 1ps

module testbench;
  import tpg_pkg::*;

  // predictor state, config copy and the queue of results still to arrive
  class pinch_scoreboard;
    logic [11:0] x_limit;
    logic [11:0] y_limit;
    logic [13:0] min_span;
    logic [14:0] upper_trg;
    logic [14:0] lower_trg;
    bit          tracking;
    logic [16:0] last_span;
    tpg_out_t    pending_results[$];
    int          errors;

    function new();
      x_limit   = 12'd319;
      y_limit   = 12'd479;
      min_span  = 14'd192;
      upper_trg = 15'd16793;
      lower_trg = 15'd15975;
      tracking  = 1'b0;
      last_span = '0;
      errors    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_SCREEN_X:  x_limit = val[11:0];
        REG_SCREEN_Y:  y_limit = val[11:0];
        REG_MIN_DIST:  min_span = val[13:0];
        REG_UPPER_TRG: upper_trg = val[14:0];
        REG_LOWER_TRG: lower_trg = val[14:0];
        default: ;
      endcase
    endfunction

    function logic [11:0] clamp_point(logic [11:0] raw, logic [11:0] lim);
      return (raw > lim) ? lim : raw;
    endfunction

    // floor square root, one result bit at a time, saturated to 17 bits
    function logic [16:0] span_sqrt(longint unsigned sq);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 18; b >= 0; b--) begin
        trial = root + (64'd1 << b);
        if (trial * trial <= sq) root = trial;
      end
      if (root > 64'd131071) root = 64'd131071;
      return root[16:0];
    endfunction

    // work out the result of one accepted report and queue it
    function void note_report(tpg_in_t rpt);
      tpg_out_t        res;
      logic [11:0]     x1, y1, x2, y2;
      longint unsigned dx, dy, ratio;
      logic [16:0]     span;
      x1 = clamp_point(rpt.first_x_raw, x_limit);
      y1 = clamp_point(rpt.first_y_raw, y_limit);
      x2 = clamp_point(rpt.second_x_raw, x_limit);
      y2 = clamp_point(rpt.second_y_raw, y_limit);
      res = '0;
      if (rpt.touch_count < 4'd2) begin
        tracking  = 1'b0;
        last_span = '0;
      end else begin
        dx = (x2 >= x1) ? longint'(x2 - x1) : longint'(x1 - x2);
        dy = (y2 >= y1) ? longint'(y2 - y1) : longint'(y1 - y2);
        span = span_sqrt((dx * dx + dy * dy) << 8);
        if (!tracking) begin
          tracking = 1'b1;
        end else if (last_span != 0 && last_span >= min_span && span >= min_span) begin
          ratio = (longint'(span) * 16384) / longint'(last_span);
          if (ratio < RATIO_MIN_Q14) ratio = RATIO_MIN_Q14;
          if (ratio > RATIO_MAX_Q14) ratio = RATIO_MAX_Q14;
          if (ratio > upper_trg || ratio < lower_trg) begin
            res.zoom_valid     = 1'b1;
            res.zoom_scale_q14 = ratio[14:0];
          end
        end
        last_span = span;
      end
      if (rpt.touch_count != 0) begin
        res.pressed = 1'b1;
        res.point_x = x1;
        res.point_y = y1;
      end
      pending_results = {pending_results, res};
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(tpg_out_t got);
      tpg_out_t want;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result expected none actual %h", $realtime, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("pressed", want.pressed, got.pressed);
      compare_field("point_x", want.point_x, got.point_x);
      compare_field("point_y", want.point_y, got.point_y);
      compare_field("zoom_valid", want.zoom_valid, got.zoom_valid);
      compare_field("zoom_scale_q14", want.zoom_scale_q14, got.zoom_scale_q14);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;
  bit                       burst;
  int                       cur_x_lim;
  int                       cur_y_lim;
  pinch_scoreboard          sb = new();

  tpg_in_if  in_chan();
  tpg_out_if out_chan();

  touch_pinch_gesture_tracker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // send one report and wait for its transaction
  task send_report(tpg_in_t rpt);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= rpt;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_report(rpt);
  endtask

  // register write; caller lowers the write enable afterwards
  task write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task configure(int xl, int yl, int mn, int up, int lo);
    write_reg(REG_SCREEN_X, CFG_DATA_BITS'(xl));
    write_reg(REG_SCREEN_Y, CFG_DATA_BITS'(yl));
    write_reg(REG_MIN_DIST, CFG_DATA_BITS'(mn));
    write_reg(REG_UPPER_TRG, CFG_DATA_BITS'(up));
    write_reg(REG_LOWER_TRG, CFG_DATA_BITS'(lo));
    cfg_we    <= 1'b0;
    cur_x_lim = xl;
    cur_y_lim = yl;
  endtask

  // wait until every result is back and the sequencer has settled
  task wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function tpg_in_t make_report(int cnt, int ax, int ay, int bx, int by);
    tpg_in_t r;
    r.touch_count  = 4'(cnt);
    r.first_x_raw  = 12'(ax);
    r.first_y_raw  = 12'(ay);
    r.second_x_raw = 12'(bx);
    r.second_y_raw = 12'(by);
    return r;
  endfunction

  // screen position to raw coordinate, now and then beyond the clamp limit
  function logic [11:0] to_raw(int v, int lim);
    if ($urandom_range(0, 9) == 0) return 12'($urandom_range(lim, 4095));
    if (v < 0) return 12'd0;
    if (v > 4095) return 12'd4095;
    return 12'(v);
  endfunction

  function tpg_in_t noise_report(int cnt);
    return make_report(cnt, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095));
  endfunction

  // pinch gestures with random drift, lifts between them and some noise
  task run_phase(int n_items);
    tpg_in_t rpt;
    int      cx, cy, ox, oy, left, f, done;
    done = 0;
    left = 0;
    while (done < n_items) begin
      if (left == 0) begin
        burst = ($urandom_range(0, 3) == 0);
        left  = $urandom_range(2, 24);
        cx    = $urandom_range(0, cur_x_lim);
        cy    = $urandom_range(0, cur_y_lim);
        ox    = $urandom_range(0, cur_x_lim / 2 + 1);
        oy    = $urandom_range(0, cur_y_lim / 2 + 1);
        if ($urandom_range(0, 1)) ox = -ox;
        if ($urandom_range(0, 1)) oy = -oy;
        // fingers lifted between gestures
        if ($urandom_range(0, 1)) begin
          send_report(noise_report($urandom_range(0, 1)));
          done++;
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        rpt = noise_report($urandom_range(0, 15));
      end else begin
        f  = $urandom_range(0, 1) ? $urandom_range(95, 105) : $urandom_range(70, 135);
        ox = ox * f / 100;
        oy = oy * f / 100;
        if (ox == 0 && oy == 0) ox = $urandom_range(1, 8);
        cx = cx + $urandom_range(0, 4) - 2;
        cy = cy + $urandom_range(0, 4) - 2;
        rpt = make_report(($urandom_range(0, 3) == 0) ? $urandom_range(2, 15) : 2,
                          to_raw(cx - ox, cur_x_lim), to_raw(cy - oy, cur_y_lim),
                          to_raw(cx + ox, cur_x_lim), to_raw(cy + oy, cur_y_lim));
      end
      send_report(rpt);
      done++;
      left--;
    end
    in_chan.valid <= 1'b0;
  endtask

  // result side: random stalls, check every transaction
  initial begin
    int stall;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
      sb.check_result(out_chan.data);
    end
  end

  // main sequence
  initial begin
    in_chan.valid <= 1'b0;
    in_chan.data  <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    burst         = 1'b0;
    cur_x_lim     = 319;
    cur_y_lim     = 479;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed reports at reset settings
    send_report(make_report(0, 4095, 4095, 4095, 4095));  // no touch, point zero
    send_report(make_report(1, 4095, 4095, 4095, 4095));  // one touch, clamped
    send_report(make_report(1, 0, 0, 0, 0));
    send_report(make_report(2, 10, 10, 110, 10));          // tracking starts
    send_report(make_report(2, 10, 10, 130, 10));          // zoom in
    send_report(make_report(2, 10, 10, 200, 10));          // clamped at upper ratio
    send_report(make_report(3, 10, 10, 100, 10));          // clamped at lower ratio
    send_report(make_report(15, 10, 10, 101, 10));         // inside dead band
    send_report(make_report(2, 10, 10, 15, 10));           // current below minimum
    send_report(make_report(2, 10, 10, 110, 10));          // previous below minimum
    send_report(make_report(2, 0, 0, 4095, 4095));         // clamped far corner
    send_report(make_report(2, 300, 400, 100, 100));       // second point before first
    send_report(make_report(1, 50, 60, 70, 80));           // lift resets tracking
    send_report(make_report(2, 0, 0, 0, 0));
    send_report(make_report(2, 0, 0, 0, 0));
    in_chan.valid <= 1'b0;
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: configure(4095, 4095, 0, 16384, 16384);
        1: configure(0, 0, 16383, 20480, 12288);
        2: configure(319, 479, 192, 16793, 15975);
        3: configure(4095, 4095, 16383, 16384, 16384);
        4: configure(32767 & 12'hFFF, 2047, 0, 32767, 0);  // triggers can never fire
        5: configure(1023, 767, 64, 0, 32767);            // triggers always fire
        default: configure($urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 16383), $urandom_range(16384, 20480),
                           $urandom_range(12288, 16384));
      endcase
      if (p == 0) begin
        // zero previous distance with a zero minimum: no division
        send_report(make_report(2, 5, 5, 5, 5));
        send_report(make_report(2, 5, 5, 5, 5));
        send_report(make_report(2, 0, 0, 50, 0));
        send_report(make_report(2, 0, 0, 60, 0));
      end
      run_phase((p == 1) ? 60 : 175);
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tpg_pkg.sv
sv/tpg_in_if.sv
sv/tpg_out_if.sv
sv/touch_pinch_gesture_tracker.sv
tb/testbench.sv
